// File: sv/spc_pkg.sv
package spc_pkg;

	// configuration port
	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 16;

	localparam logic [CFG_IDX_W-1:0] CFG_DEBOUNCE = 3'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_BAR4     = 3'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_BAR3     = 3'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_BAR2     = 3'd3;
	localparam logic [CFG_IDX_W-1:0] CFG_BAR1     = 3'd4;

	// register reset values
	localparam logic [15:0] DEBOUNCE_RST = 16'd40;
	localparam logic [7:0]  BAR4_RST     = 8'd40;
	localparam logic [7:0]  BAR3_RST     = 8'd55;
	localparam logic [7:0]  BAR2_RST     = 8'd70;
	localparam logic [7:0]  BAR1_RST     = 8'd80;

	// mode switch codes
	localparam logic [1:0] MODE_AP     = 2'd0;
	localparam logic [1:0] MODE_STA    = 2'd1;
	localparam logic [1:0] MODE_GROUP  = 2'd2;
	localparam logic [1:0] MODE_UNUSED = 2'd3;

	// bar counts
	localparam logic [2:0] BARS_NONE = 3'd0;
	localparam logic [2:0] BARS_ONE  = 3'd1;
	localparam logic [2:0] BARS_TWO  = 3'd2;
	localparam logic [2:0] BARS_THREE = 3'd3;
	localparam logic [2:0] BARS_FOUR = 3'd4;

	// button levels
	localparam logic BTN_PRESSED  = 1'b0;
	localparam logic BTN_RELEASED = 1'b1;

	typedef struct packed {
		logic [15:0] debounce_ms;
		logic [7:0]  bar4_limit;
		logic [7:0]  bar3_limit;
		logic [7:0]  bar2_limit;
		logic [7:0]  bar1_limit;
	} cfg_t;

	typedef struct packed {
		logic [2:0] bar_count;
		logic       pairing_on;
		logic       press_seen;
		logic [1:0] active_mode;
		logic       reconfigure;
	} panel_t;

endpackage

// File: sv/status_panel_controller.sv
// A result beat shows on out_valid once its poll has passed the input register, stages 2 and 3
// and the output register. Throughput: one poll per cycle unless out_ready stalls a full pipeline;
// button, switch and bar logic are combinational, the blink phase (now_ms / BLINK_HALF_MS) takes
// a reciprocal multiply and a back-multiply. Every stage holds independently, so input is still
// taken while a result waits. Reset (arst_n low, asynchronous): pipeline empty, config at defaults,
// button released, pairing and press mark clear, mode access point, switch not yet seen.
module status_panel_controller import spc_pkg::*; #(
	parameter int BLINK_HALF_MS = 150
) (
	input  logic                  clk,
	input  logic                  arst_n,
	// config write channel
	input  logic                  cfg_valid,
	output logic                  cfg_ready,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data,
	// poll channel
	input  logic                  in_valid,
	output logic                  in_ready,
	input  logic [31:0]           now_ms,
	input  logic                  button_level,
	input  logic [1:0]            switch_mode,
	input  logic                  link_connected,
	input  logic [7:0]            station_count,
	input  logic signed [7:0]     signal_dbm,
	// result channel
	output logic                  out_valid,
	input  logic                  out_ready,
	output logic [2:0]            bar_count,
	output logic                  link_led,
	output logic                  pairing_on,
	output logic                  press_seen,
	output logic [1:0]            active_mode,
	output logic                  reconfigure
);

	cfg_t   cfg;
	panel_t panel;

	// stage 1: input register
	logic        v_s1;
	logic [31:0] now_s1;
	logic        btn_s1;
	logic [1:0]  sw_s1;
	logic        link_s1;
	logic [7:0]  sta_s1;
	logic [7:0]  sig_s1;

	// stages 2 and 3 carry panel result while the blink phase resolves
	logic   v_s2;
	panel_t panel_s2;
	logic   link_s2;
	logic   v_s3;
	panel_t panel_s3;
	logic   link_s3;

	// stage 4: output register
	logic   v_s4;
	panel_t panel_s4;
	logic   led_s4;

	logic load_s1;
	logic load_s2;
	logic load_s3;
	logic load_s4;
	logic blink;

	// per-stage hold: a stage loads when its source is full and it is empty or draining
	assign load_s4  = v_s3 && (!v_s4 || out_ready);
	assign load_s3  = v_s2 && (!v_s3 || load_s4);
	assign load_s2  = v_s1 && (!v_s2 || load_s3);
	assign in_ready = !v_s1 || load_s2;
	assign load_s1  = in_valid && in_ready;

	// config is always writable; the user must write it only while idle, the block does not enforce it
	assign cfg_ready = 1'b1;

	spc_cfg u_cfg (
		.clk      (clk),
		.arst_n   (arst_n),
		.wr_en    (cfg_valid),
		.wr_index (cfg_index),
		.wr_data  (cfg_data),
		.cfg      (cfg)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
		end else begin
			if (load_s1)      v_s1 <= 1'b1;
			else if (load_s2) v_s1 <= 1'b0;
			if (load_s2)      v_s2 <= 1'b1;
			else if (load_s3) v_s2 <= 1'b0;
			if (load_s3)      v_s3 <= 1'b1;
			else if (load_s4) v_s3 <= 1'b0;
			if (load_s4)      v_s4 <= 1'b1;
			else if (out_ready) v_s4 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load_s1) begin
			now_s1  <= now_ms;
			btn_s1  <= button_level;
			sw_s1   <= switch_mode;
			link_s1 <= link_connected;
			sta_s1  <= station_count;
			sig_s1  <= signal_dbm;
		end
	end

	// panel state commits exactly once per poll, as it leaves stage 1
	spc_panel u_panel (
		.clk            (clk),
		.arst_n         (arst_n),
		.commit         (load_s2),
		.cfg            (cfg),
		.now_ms         (now_s1),
		.button_level   (btn_s1),
		.switch_mode    (sw_s1),
		.link_connected (link_s1),
		.station_count  (sta_s1),
		.signal_dbm     (sig_s1),
		.res            (panel)
	);

	spc_blink #(
		.BLINK_HALF_MS (BLINK_HALF_MS)
	) u_blink (
		.clk    (clk),
		.en_s2  (load_s2),
		.en_s3  (load_s3),
		.now_ms (now_s1),
		.blink  (blink)
	);

	always_ff @(posedge clk) begin
		if (load_s2) begin
			panel_s2 <= panel;
			link_s2  <= link_s1;
		end
		if (load_s3) begin
			panel_s3 <= panel_s2;
			link_s3  <= link_s2;
		end
		if (load_s4) begin
			panel_s4 <= panel_s3;
			// LED blinks while pairing, else follows the link
			led_s4   <= panel_s3.pairing_on ? blink : link_s3;
		end
	end

	assign out_valid   = v_s4;
	assign bar_count   = panel_s4.bar_count;
	assign link_led    = led_s4;
	assign pairing_on  = panel_s4.pairing_on;
	assign press_seen  = panel_s4.press_seen;
	assign active_mode = panel_s4.active_mode;
	assign reconfigure = panel_s4.reconfigure;

`ifndef SYNTHESIS
	a_ready_blocked_only_when_full: assert property (@(posedge clk) disable iff (!arst_n)
		!in_ready |-> v_s1)
		else $error("in_ready low with empty input stage");

	a_mode_valid: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> active_mode != MODE_UNUSED)
		else $error("unused mode stored");

	a_bar_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> bar_count <= BARS_FOUR)
		else $error("bar count out of range");

	a_led_follows_link: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !pairing_on && bar_count != BARS_NONE |-> link_led)
		else $error("bars lit with link LED off outside pairing");
`endif

endmodule

// File: sv/spc_cfg.sv
module spc_cfg import spc_pkg::*; (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  wr_en,
	input  logic [CFG_IDX_W-1:0]  wr_index,
	input  logic [CFG_DATA_W-1:0] wr_data,
	output cfg_t                  cfg
);

	cfg_t cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.debounce_ms <= DEBOUNCE_RST;
			cfg_q.bar4_limit  <= BAR4_RST;
			cfg_q.bar3_limit  <= BAR3_RST;
			cfg_q.bar2_limit  <= BAR2_RST;
			cfg_q.bar1_limit  <= BAR1_RST;
		end else if (wr_en) begin
			unique case (wr_index)
				CFG_DEBOUNCE: cfg_q.debounce_ms <= wr_data;
				CFG_BAR4:     cfg_q.bar4_limit  <= wr_data[7:0];
				CFG_BAR3:     cfg_q.bar3_limit  <= wr_data[7:0];
				CFG_BAR2:     cfg_q.bar2_limit  <= wr_data[7:0];
				CFG_BAR1:     cfg_q.bar1_limit  <= wr_data[7:0];
				default: ;	// unknown index: dropped
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule

// File: sv/spc_panel.sv
module spc_panel import spc_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        commit,
	input  cfg_t        cfg,
	input  logic [31:0] now_ms,
	input  logic        button_level,
	input  logic [1:0]  switch_mode,
	input  logic        link_connected,
	input  logic [7:0]  station_count,
	input  logic [7:0]  signal_dbm,
	output panel_t      res
);

	logic        raw_last_q;
	logic [31:0] stable_since_q;
	logic        debounced_q;
	logic        pairing_q;
	logic        press_q;
	logic [1:0]  switch_last_q;
	logic        switch_seen_q;
	logic [1:0]  mode_q;

	logic        level_moved;
	logic [31:0] held_ms;
	logic        accept_level;
	logic        press_evt;
	logic        switch_chg;
	logic        mode_upd;
	logic [1:0]  mode_nxt;
	logic [7:0]  loss_mag;
	logic [2:0]  sig_bars;
	logic [2:0]  bars;

	// debounce: signed elapsed time, negative never accepts
	assign level_moved  = button_level != raw_last_q;
	assign held_ms      = now_ms - stable_since_q;
	assign accept_level = !level_moved && !held_ms[31]
		&& (held_ms >= {16'd0, cfg.debounce_ms}) && (button_level != debounced_q);
	assign press_evt    = accept_level && (button_level == BTN_PRESSED);

	// first poll after reset always counts as a switch change
	assign switch_chg = !switch_seen_q || (switch_mode != switch_last_q);
	assign mode_upd   = switch_chg && (switch_mode != MODE_UNUSED) && (switch_mode != mode_q);
	assign mode_nxt   = mode_upd ? switch_mode : mode_q;

	// -128 negates to 0x80, read unsigned as 128
	assign loss_mag = signal_dbm[7] ? (~signal_dbm + 8'd1) : 8'd0;

	always_comb begin
		priority if (loss_mag <= cfg.bar4_limit) sig_bars = BARS_FOUR;
		else if (loss_mag <= cfg.bar3_limit)     sig_bars = BARS_THREE;
		else if (loss_mag <= cfg.bar2_limit)     sig_bars = BARS_TWO;
		else if (loss_mag <= cfg.bar1_limit)     sig_bars = BARS_ONE;
		else                                     sig_bars = BARS_NONE;
	end

	always_comb begin
		if (!link_connected)
			bars = BARS_NONE;
		else if (mode_nxt == MODE_AP)
			bars = (station_count != 8'd0) ? BARS_TWO : BARS_NONE;
		else
			bars = sig_bars;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			raw_last_q     <= BTN_RELEASED;
			stable_since_q <= 32'd0;
			debounced_q    <= BTN_RELEASED;
			pairing_q      <= 1'b0;
			press_q        <= 1'b0;
			switch_last_q  <= MODE_AP;
			switch_seen_q  <= 1'b0;
			mode_q         <= MODE_AP;
		end else if (commit) begin
			if (level_moved) begin
				raw_last_q     <= button_level;
				stable_since_q <= now_ms;
			end
			if (accept_level)
				debounced_q <= button_level;
			if (press_evt) begin
				pairing_q <= ~pairing_q;
				press_q   <= 1'b1;
			end
			if (switch_chg) begin
				switch_seen_q <= 1'b1;
				switch_last_q <= switch_mode;
			end
			mode_q <= mode_nxt;
		end
	end

	assign res.bar_count   = bars;
	assign res.pairing_on  = pairing_q ^ press_evt;
	assign res.press_seen  = press_q | press_evt;
	assign res.active_mode = mode_nxt;
	assign res.reconfigure = mode_upd;

endmodule

// File: sv/spc_blink.sv
module spc_blink #(
	parameter int BLINK_HALF_MS = 150
) (
	input  logic        clk,
	input  logic        en_s2,
	input  logic        en_s3,
	input  logic [31:0] now_ms,
	output logic        blink
);

	// q = now / BLINK_HALF_MS: reciprocal estimate is low by at most two
	localparam logic [63:0] RECIP_W = 64'h0000_0000_FFFF_FFFF / 64'(BLINK_HALF_MS);
	localparam logic [31:0] RECIP   = RECIP_W[31:0];
	localparam logic [15:0] DIV     = 16'(BLINK_HALF_MS);
	localparam logic [31:0] DIV_X1  = 32'(BLINK_HALF_MS);
	localparam logic [31:0] DIV_X2  = 32'(2 * BLINK_HALF_MS);

	logic [63:0] recip_prod;
	logic [31:0] qest_s2;
	logic [31:0] now_s2;
	logic [47:0] back_prod;
	logic [31:0] qd_s3;
	logic [31:0] now_s3;
	logic        qlsb_s3;
	logic [31:0] rem;

	assign recip_prod = now_ms * RECIP;

	always_ff @(posedge clk) begin
		if (en_s2) begin
			qest_s2 <= recip_prod[63:32];
			now_s2  <= now_ms;
		end
	end

	assign back_prod = qest_s2 * DIV;

	always_ff @(posedge clk) begin
		if (en_s3) begin
			qd_s3   <= back_prod[31:0];
			now_s3  <= now_s2;
			qlsb_s3 <= qest_s2[0];
		end
	end

	// rem < 3*DIV; one correction flips bit 0, two leave it
	assign rem   = now_s3 - qd_s3;
	assign blink = qlsb_s3 ^ ((rem >= DIV_X1) && (rem < DIV_X2));

endmodule

// File: test/tb_status_panel_controller.sv
module tb_status_panel_controller;
	timeunit 1ns;
	timeprecision 1ps;
	import spc_pkg::*;

	localparam int BLINK_HALF_MS = 150;
	localparam int STALL_LIMIT   = 2000;  // cycles with no beat on any channel
	localparam int DRAIN_CYCLES  = 20;    // pipeline holds up to 4 polls, leave margin
	localparam int N_PHASES      = 9;
	localparam int PHASE_POLLS   = 205;
	localparam int REPORT_MAX    = 10;
	localparam int N_DIRECTED    = 25;

	// one poll sample as seen on the input channel
	typedef struct packed {
		logic [31:0]       now;
		logic              btn;
		logic [1:0]        sw;
		logic              link;
		logic [7:0]        stations;
		logic signed [7:0] sig;
	} poll_t;

	// full panel state returned per poll, in port order
	typedef struct packed {
		logic [2:0] bars;
		logic       led;
		logic       pairing;
		logic       pressed;
		logic [1:0] mode;
		logic       reconf;
	} panel_view_t;

	// hand-typed answer for a directed row, or none
	typedef struct {
		bit          typed;
		panel_view_t view;
	} preset_t;

	typedef struct {
		poll_t       poll;
		bit          typed;
		panel_view_t view;
	} poll_row_t;

	logic clk    = 1'b0;
	logic arst_n = 1'b0;

	logic                  cfg_valid = 1'b0;
	logic                  cfg_ready;
	logic [CFG_IDX_W-1:0]  cfg_index = '0;
	logic [CFG_DATA_W-1:0] cfg_data  = '0;

	logic              in_valid       = 1'b0;
	logic              in_ready;
	logic [31:0]       now_ms         = '0;
	logic              button_level   = BTN_RELEASED;
	logic [1:0]        switch_mode    = MODE_AP;
	logic              link_connected = 1'b0;
	logic [7:0]        station_count  = '0;
	logic signed [7:0] signal_dbm     = '0;

	logic       out_valid;
	logic       out_ready = 1'b0;
	logic [2:0] bar_count;
	logic       link_led;
	logic       pairing_on;
	logic       press_seen;
	logic [1:0] active_mode;
	logic       reconfigure;

	status_panel_controller #(.BLINK_HALF_MS(BLINK_HALF_MS)) dut (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.now_ms(now_ms),
		.button_level(button_level),
		.switch_mode(switch_mode),
		.link_connected(link_connected),
		.station_count(station_count),
		.signal_dbm(signal_dbm),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.bar_count(bar_count),
		.link_led(link_led),
		.pairing_on(pairing_on),
		.press_seen(press_seen),
		.active_mode(active_mode),
		.reconfigure(reconfigure)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// ------------------------------------------------------------------
	// Panel predictor: own copy of the registers and the panel state
	// ------------------------------------------------------------------
	logic [15:0] db_ms;
	logic [7:0]  lim4, lim3, lim2, lim1;

	logic        btn_raw;       // last raw level seen
	logic [31:0] hold_start;    // tick at which the raw level last changed
	logic        btn_stable;    // debounced level
	logic        pairing;
	logic        pressed_once;
	logic        sw_seen;
	logic [1:0]  sw_prev;
	logic [1:0]  mode_now;

	function automatic void reset_panel_model();
		db_ms        = DEBOUNCE_RST;
		lim4         = BAR4_RST;
		lim3         = BAR3_RST;
		lim2         = BAR2_RST;
		lim1         = BAR1_RST;
		btn_raw      = BTN_RELEASED;
		hold_start   = '0;
		btn_stable   = BTN_RELEASED;
		pairing      = 1'b0;
		pressed_once = 1'b0;
		sw_seen      = 1'b0;
		sw_prev      = MODE_AP;
		mode_now     = MODE_AP;
	endfunction

	// limit writes land only in the low byte, debounce takes all 16 bits; unknown indexes drop
	function automatic void store_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
		case (idx)
			CFG_DEBOUNCE: db_ms = data;
			CFG_BAR4:     lim4  = data[7:0];
			CFG_BAR3:     lim3  = data[7:0];
			CFG_BAR2:     lim2  = data[7:0];
			CFG_BAR1:     lim1  = data[7:0];
			default: ;
		endcase
	endfunction

	function automatic logic [2:0] bars_for_signal(logic signed [7:0] sig);
		logic [8:0] loss;
		// positive or zero dBm counts as no loss; -128 gives 128
		loss = sig[7] ? (9'h100 - {1'b0, sig}) : 9'd0;
		if (loss <= {1'b0, lim4}) return BARS_FOUR;
		if (loss <= {1'b0, lim3}) return BARS_THREE;
		if (loss <= {1'b0, lim2}) return BARS_TWO;
		if (loss <= {1'b0, lim1}) return BARS_ONE;
		return BARS_NONE;
	endfunction

	function automatic panel_view_t step_panel(poll_t p);
		panel_view_t v;
		logic [31:0] age;
		logic [31:0] blink_phase;
		v = '0;
		// debounce: any raw edge restarts the hold timer
		if (p.btn != btn_raw) begin
			btn_raw    = p.btn;
			hold_start = p.now;
		end else begin
			age = p.now - hold_start;
			// age read as signed: a tick going backwards never qualifies
			if (!age[31] && age >= {16'd0, db_ms} && p.btn != btn_stable) begin
				btn_stable = p.btn;
				if (p.btn == BTN_PRESSED) begin
					pairing      = ~pairing;
					pressed_once = 1'b1;
				end
			end
		end
		// switch: first poll always counts as a change, value 3 never takes
		if (!sw_seen || p.sw != sw_prev) begin
			sw_seen = 1'b1;
			sw_prev = p.sw;
			if (p.sw != MODE_UNUSED && p.sw != mode_now) begin
				mode_now = p.sw;
				v.reconf = 1'b1;
			end
		end
		// bars use the mode after this poll's update
		if (!p.link)
			v.bars = BARS_NONE;
		else if (mode_now == MODE_AP)
			v.bars = (p.stations != 8'd0) ? BARS_TWO : BARS_NONE;
		else
			v.bars = bars_for_signal(p.sig);
		blink_phase = p.now / 32'(BLINK_HALF_MS);
		v.led     = pairing ? blink_phase[0] : p.link;
		v.pairing = pairing;
		v.pressed = pressed_once;
		v.mode    = mode_now;
		return v;
	endfunction

	// ------------------------------------------------------------------
	// Scoreboard
	// ------------------------------------------------------------------
	panel_view_t expected_panel_q[$];
	preset_t     preset_q[$];
	int unsigned polls_sent   = 0;
	int unsigned results_seen = 0;
	int unsigned fail_count   = 0;
	int unsigned idle_cycles  = 0;
	int          send_idle_pct = 0;
	int          recv_idle_pct = 0;

	function automatic void note_fail(string msg);
		fail_count++;
		if (fail_count <= REPORT_MAX)
			$display("[%0t] ERROR: %s", $realtime, msg);
	endfunction

	// Samples every channel at the edge; results are checked before the poll
	// taken on the same edge is pushed, since that poll cannot be answered yet.
	always @(posedge clk) begin : monitor
		panel_view_t want;
		panel_view_t got;
		preset_t     pre;
		poll_t       p;
		if (arst_n) begin
			if (out_valid && out_ready) begin
				results_seen++;
				got = {bar_count, link_led, pairing_on, press_seen,
					active_mode, reconfigure};
				if (expected_panel_q.size() == 0) begin
					note_fail($sformatf({"result beat with nothing expected:",
						" bars=%0d led=%0b pair=%0b press=%0b mode=%0d reconf=%0b"},
						got.bars, got.led, got.pairing, got.pressed, got.mode, got.reconf));
				end else begin
					want = expected_panel_q.pop_front();
					if (got.bars !== want.bars || got.led !== want.led ||
							got.pairing !== want.pairing || got.pressed !== want.pressed ||
							got.mode !== want.mode || got.reconf !== want.reconf) begin
						note_fail($sformatf({"result #%0d: exp bars=%0d led=%0b pair=%0b",
							" press=%0b mode=%0d reconf=%0b",
							" / got bars=%0d led=%0b pair=%0b",
							" press=%0b mode=%0d reconf=%0b"},
							results_seen - 1,
							want.bars, want.led, want.pairing, want.pressed, want.mode, want.reconf,
							got.bars, got.led, got.pairing, got.pressed, got.mode, got.reconf));
					end
				end
			end
			if (in_valid && in_ready) begin
				p   = {now_ms, button_level, switch_mode, link_connected,
					station_count, signal_dbm};
				pre = preset_q.pop_front();
				// predictor always runs so its state follows the block
				want = step_panel(p);
				expected_panel_q.push_back(pre.typed ? pre.view : want);
			end
			if (cfg_valid && cfg_ready)
				store_reg(cfg_index, cfg_data);
		end
	end

	// Watchdog: any beat on any channel resets it
	always @(posedge clk) begin
		if (arst_n) begin
			if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready))
				idle_cycles <= 0;
			else
				idle_cycles <= idle_cycles + 1;
			if (idle_cycles >= STALL_LIMIT) begin
				$display("Test completed with failures");
				$finish;
			end
		end
	end

	// Result side backpressure
	always @(posedge clk)
		out_ready <= ($urandom_range(99) >= recv_idle_pct);

	// ------------------------------------------------------------------
	// Drivers
	// ------------------------------------------------------------------
	task automatic send_poll(poll_t p, bit typed, panel_view_t view);
		preset_t pre;
		pre.typed = typed;
		pre.view  = view;
		while ($urandom_range(99) < send_idle_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		preset_q.push_back(pre);
		in_valid       <= 1'b1;
		now_ms         <= p.now;
		button_level   <= p.btn;
		switch_mode    <= p.sw;
		link_connected <= p.link;
		station_count  <= p.stations;
		signal_dbm     <= p.sig;
		do @(posedge clk); while (!in_ready);
		polls_sent++;
	endtask

	// valid stays up across back-to-back writes; caller lowers it
	task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= data;
		do @(posedge clk); while (!cfg_ready);
	endtask

	// results_seen may read stale, which only lengthens the wait
	task automatic wait_drained();
		while (results_seen < polls_sent) @(posedge clk);
	endtask

	// Directed rows. Typed answers only where they are obvious: the first
	// polls after reset and the signal extremes. Then every bar threshold,
	// the unused switch value, link down outside AP mode, a press through
	// the debounce, a backward tick, and a press held across the wrap.
	poll_row_t directed [N_DIRECTED] = '{
		'{'{32'd0,   BTN_RELEASED, MODE_AP,     1'b0, 8'd0,   8'sd0},   1'b1,
			'{BARS_NONE, 1'b0, 1'b0, 1'b0, MODE_AP,  1'b0}},
		'{'{32'd10,  BTN_RELEASED, MODE_AP,     1'b1, 8'd0,   8'sd0},   1'b1,
			'{BARS_NONE, 1'b1, 1'b0, 1'b0, MODE_AP,  1'b0}},
		'{'{32'd20,  BTN_RELEASED, MODE_AP,     1'b1, 8'd255, 8'sd0},   1'b1,
			'{BARS_TWO,  1'b1, 1'b0, 1'b0, MODE_AP,  1'b0}},
		'{'{32'd30,  BTN_RELEASED, MODE_STA,    1'b1, 8'd0,   8'sd127}, 1'b1,
			'{BARS_FOUR, 1'b1, 1'b0, 1'b0, MODE_STA, 1'b1}},
		'{'{32'd40,  BTN_RELEASED, MODE_STA,    1'b1, 8'd0,   -8'sd128}, 1'b1,
			'{BARS_NONE, 1'b1, 1'b0, 1'b0, MODE_STA, 1'b0}},
		'{'{32'd50,  BTN_RELEASED, MODE_GROUP,  1'b1, 8'd0,   -8'sd40}, 1'b0, '0},
		'{'{32'd60,  BTN_RELEASED, MODE_UNUSED, 1'b1, 8'd0,   -8'sd41}, 1'b0, '0},
		'{'{32'd70,  BTN_RELEASED, MODE_UNUSED, 1'b1, 8'd0,   -8'sd55}, 1'b0, '0},
		'{'{32'd80,  BTN_RELEASED, MODE_GROUP,  1'b1, 8'd0,   -8'sd56}, 1'b0, '0},
		'{'{32'd90,  BTN_RELEASED, MODE_GROUP,  1'b1, 8'd0,   -8'sd70}, 1'b0, '0},
		'{'{32'd100, BTN_RELEASED, MODE_GROUP,  1'b1, 8'd0,   -8'sd71}, 1'b0, '0},
		'{'{32'd110, BTN_RELEASED, MODE_GROUP,  1'b1, 8'd0,   -8'sd80}, 1'b0, '0},
		'{'{32'd120, BTN_RELEASED, MODE_GROUP,  1'b1, 8'd0,   -8'sd81}, 1'b0, '0},
		'{'{32'd130, BTN_RELEASED, MODE_GROUP,  1'b0, 8'd9,   8'sd127}, 1'b0, '0},
		'{'{32'd200, BTN_PRESSED,  MODE_GROUP,  1'b1, 8'd0,   -8'sd30}, 1'b0, '0},
		'{'{32'd220, BTN_PRESSED,  MODE_GROUP,  1'b1, 8'd0,   -8'sd30}, 1'b0, '0},
		'{'{32'd240, BTN_PRESSED,  MODE_GROUP,  1'b1, 8'd0,   -8'sd30}, 1'b0, '0},
		'{'{32'd300, BTN_PRESSED,  MODE_GROUP,  1'b1, 8'd0,   -8'sd30}, 1'b0, '0},
		'{'{32'd310, BTN_RELEASED, MODE_GROUP,  1'b1, 8'd0,   -8'sd30}, 1'b0, '0},
		'{'{32'd350, BTN_RELEASED, MODE_GROUP,  1'b0, 8'd0,   -8'sd30}, 1'b0, '0},
		'{'{32'd400, BTN_PRESSED,  MODE_STA,    1'b1, 8'd0,   -8'sd1},  1'b0, '0},
		'{'{32'd390, BTN_PRESSED,  MODE_STA,    1'b1, 8'd0,   -8'sd1},  1'b0, '0},
		'{'{32'hFFFF_FFF0, BTN_RELEASED, MODE_STA, 1'b1, 8'd0, -8'sd1}, 1'b0, '0},
		'{'{32'hFFFF_FFFF, BTN_PRESSED,  MODE_STA, 1'b1, 8'd0, -8'sd1}, 1'b0, '0},
		'{'{32'h0000_0027, BTN_PRESSED,  MODE_AP,  1'b1, 8'd1, -8'sd1}, 1'b0, '0}
	};

	// ------------------------------------------------------------------
	// Test sequence
	// ------------------------------------------------------------------
	initial begin : stimulus
		poll_t       p;
		logic [15:0] db_set;
		logic [15:0] lim_set [4];
		logic [31:0] t_now;
		logic        cur_btn;
		logic [1:0]  cur_sw;
		int          span;
		int          roll;

		reset_panel_model();
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		send_idle_pct = 22;
		recv_idle_pct = 52;

		// directed part runs on the reset register values
		for (int i = 0; i < N_DIRECTED; i++)
			send_poll(directed[i].poll, directed[i].typed, directed[i].view);

		t_now   = 32'd1000;
		cur_btn = BTN_RELEASED;
		cur_sw  = MODE_STA;

		for (int ph = 0; ph < N_PHASES; ph++) begin
			// idling profile changes every third phase
			if (ph == 3) begin
				send_idle_pct = 52;
				recv_idle_pct = 22;
			end else if (ph == 6) begin
				send_idle_pct = 0;
				recv_idle_pct = 0;
			end

			// registers only change with the pipeline empty
			in_valid <= 1'b0;
			wait_drained();

			case (ph)
				0: begin
					// low extremes: shortest nonzero debounce, every limit at zero
					db_set = 16'd1;
					foreach (lim_set[j]) lim_set[j] = 16'h0000;
				end
				1: begin
					// high extremes; limit writes carry junk in the upper byte
					db_set = 16'hFFFF;
					foreach (lim_set[j]) lim_set[j] = 16'hFFFF;
				end
				2: begin
					// zero debounce accepts on the first steady poll
					db_set = 16'd0;
					foreach (lim_set[j]) lim_set[j] = 16'hA580;
				end
				default: begin
					db_set = ($urandom_range(3) == 0) ? 16'($urandom_range(1, 65535))
						: 16'($urandom_range(1, 300));
					foreach (lim_set[j])
						lim_set[j] = {8'($urandom_range(255)), 8'($urandom_range(0, 140))};
				end
			endcase

			write_reg(CFG_DEBOUNCE, db_set);
			write_reg(CFG_BAR4, lim_set[0]);
			write_reg(CFG_BAR3, lim_set[1]);
			write_reg(CFG_BAR2, lim_set[2]);
			write_reg(CFG_BAR1, lim_set[3]);
			// an index past the last register must be dropped
			write_reg(CFG_IDX_W'(5 + $urandom_range(2)), 16'($urandom));
			cfg_valid <= 1'b0;

			// step size scales with the debounce so holds still qualify
			span = int'(db_set) / 4 + 2;
			if (ph % 3 == 1)
				t_now = 32'hFFFF_FFFF - 32'($urandom_range(0, 4 * span));

			for (int k = 0; k < PHASE_POLLS; k++) begin
				roll = $urandom_range(99);
				if (roll < 4)
					t_now = $urandom;          // arbitrary jump, also backwards
				else
					t_now = t_now + 32'($urandom_range(0, span));

				// mostly held button runs, some single-poll glitches
				roll = $urandom_range(99);
				if (roll < 9)
					cur_btn = ~cur_btn;
				p.btn = (roll >= 9 && roll < 13) ? ~cur_btn : cur_btn;

				if ($urandom_range(99) < 8)
					cur_sw = 2'($urandom_range(3));
				p.sw       = cur_sw;
				p.now      = t_now;
				p.link     = ($urandom_range(99) < 85);
				p.stations = ($urandom_range(2) == 0) ? 8'd0 : 8'($urandom_range(255));
				p.sig      = 8'($urandom_range(255));
				send_poll(p, 1'b0, '0);
			end
		end

		in_valid <= 1'b0;
		wait_drained();
		repeat (DRAIN_CYCLES) @(posedge clk);

		if (expected_panel_q.size() != 0)
			note_fail($sformatf("%0d expected results never arrived", expected_panel_q.size()));

		if (fail_count == 0)
			$display("Test completed successfully");
		else
			$display("Test completed with failures");
		$finish;
	end

endmodule
